// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file pvt_check.sv.
// Each macro expands to one labeled concurrent assertion on clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pvt_pkg.sv -----
// Types, constants and helper functions for the position and velocity tracker.
// Used by pvt_div and position_velocity_tracker.
`timescale 1ns / 1ps

package pvt_pkg;

	localparam int POS_W     = 12;
	localparam int VEL_W     = 21;
	localparam int CAP_W     = 20;
	localparam int ALPHA_W   = 9;
	localparam int RATIO_W   = 18;
	localparam int TIME_W    = 32;
	localparam int CNT_W     = 8;
	localparam int DT_W      = 10;
	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 10;
	localparam int DIV_CNT_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 20;
	localparam int MUL_A_W   = 10;
	localparam int MUL_B_W   = 32;
	localparam int PROD_W    = 43;
	localparam int RND_W     = 35;

	localparam logic [1:0] MODE_RESTART = 2'd0;
	localparam logic [1:0] MODE_MISS    = 2'd1;
	localparam logic [1:0] MODE_DETECT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_VEL_ALPHA   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ALPHA = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_CAP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_CAP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_CAP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_JUMP = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_JUMP = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT  = 3'd7;

	localparam logic [1:0] CH_MARKER = 2'd0;
	localparam logic [1:0] CH_TARGET = 2'd1;
	localparam logic [1:0] CH_ACCEL  = 2'd2;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_PREP  = 13'b0000000000010,
		S_RATIO = 13'b0000000000100,
		S_DEC1  = 13'b0000000001000,
		S_DEC2  = 13'b0000000010000,
		S_DEC3  = 13'b0000000100000,
		S_CHAN  = 13'b0000001000000,
		S_DIFF  = 13'b0000010000000,
		S_VDIV  = 13'b0000100000000,
		S_EMA1  = 13'b0001000000000,
		S_EMA2  = 13'b0010000000000,
		S_EMA3  = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	// Q.8 round to nearest, ties away from zero.
	function automatic logic signed [RND_W-1:0] rnd8(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] m;
		logic signed [PROD_W-1:0] r;
		m = (x < 0) ? -x : x;
		r = (m + PROD_W'(128)) >>> 8;
		if (x < 0)
			r = -r;
		return r[RND_W-1:0];
	endfunction

	function automatic logic signed [VEL_W-1:0] clamp_mag(input logic signed [RND_W-1:0] v,
			input logic [CAP_W-1:0] cap);
		logic signed [RND_W-1:0] c;
		logic signed [RND_W-1:0] r;
		c = $signed({{(RND_W-CAP_W){1'b0}}, cap});
		if (v > c)
			r = c;
		else if (v < -c)
			r = -c;
		else
			r = v;
		return r[VEL_W-1:0];
	endfunction

	function automatic logic [POS_W:0] abs_diff(input logic [POS_W-1:0] a,
			input logic [POS_W-1:0] b);
		return (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

	function automatic logic [ALPHA_W-1:0] alpha_clamp(input logic [ALPHA_W-1:0] r);
		if (r < ALPHA_W'(13))
			return ALPHA_W'(13);
		else if (r > ALPHA_W'(256))
			return ALPHA_W'(256);
		return r;
	endfunction

endpackage

// ----- rtl/position_velocity_tracker.sv -----
// Position and velocity tracker: gates positions and keeps smoothed velocities.
// Depends on pvt_pkg and pvt_div.
//
// Input channel (in_valid / in_stall) carries one frame item: restart, miss or
// detection. Output channel (out_valid / out_stall) returns one result item per
// frame. Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// One item is worked at a time; in_stall is high from acceptance until the
// sequencer is back in idle. Restart, miss and unused mode go from S_PREP
// straight to S_OUT, where the output register loads. A detection shares one
// multiplier and one bit-serial divider: the step ratio is a reciprocal
// multiply, each valid velocity takes a divide and the acceleration none.
// The next item can be taken in the cycle after the result loads. A finished
// result waits in the output register while out_stall is high; the next item
// is accepted meanwhile but its result holds until the register frees. Reset
// clears all tracking state and loads the configuration defaults; no item is
// in flight.
`timescale 1ns / 1ps

module position_velocity_tracker #(
	parameter int BASE_STEP_MS   = 16,
	parameter int RELEASE_MISSES = 3,
	parameter int END_FRAMES     = 30
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         mode,
	input  logic [pvt_pkg::POS_W-1:0]          target_pos,
	input  logic [pvt_pkg::POS_W-1:0]          marker_center,
	input  logic [pvt_pkg::POS_W-1:0]          marker_height,
	input  logic                               has_bounds,
	input  logic [pvt_pkg::TIME_W-1:0]         time_ms,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pvt_pkg::POS_W-1:0]          target_out,
	output logic [pvt_pkg::POS_W-1:0]          marker_out,
	output logic [pvt_pkg::POS_W-1:0]          height_out,
	output logic signed [pvt_pkg::VEL_W-1:0]   marker_velocity,
	output logic signed [pvt_pkg::VEL_W-1:0]   target_velocity,
	output logic signed [pvt_pkg::VEL_W-1:0]   target_accel,
	output logic [pvt_pkg::RATIO_W-1:0]        step_ratio,
	output logic                               release_request,
	output logic                               round_end,
	input  logic                               cfg_we,
	input  logic [pvt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pvt_pkg::CFG_W-1:0]          cfg_data
);
	import pvt_pkg::*;

	// step ratio numerator dt*256 + base/2 stays below 2^18
	localparam int RATIO_NUM_W = 18;
	localparam int RATIO_SH = RATIO_NUM_W + $clog2(BASE_STEP_MS);
	localparam longint RATIO_M = ((longint'(1) << RATIO_SH) + BASE_STEP_MS - 1) / BASE_STEP_MS;
	localparam logic signed [MUL_B_W-1:0] RATIO_MUL = MUL_B_W'(RATIO_M * 256);
	localparam logic signed [PROD_W-1:0] RATIO_ADD = PROD_W'(RATIO_M * (BASE_STEP_MS / 2));
	localparam logic [CNT_W-1:0] REL_CNT = CNT_W'(RELEASE_MISSES);
	localparam logic [CNT_W-1:0] END_CNT = CNT_W'(END_FRAMES);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// configuration
	logic [ALPHA_W-1:0] va_q, aa_q;
	logic [CAP_W-1:0]   mcap_q, tcap_q, acap_q;
	logic [POS_W-1:0]   mjump_q, tjump_q, minh_q;

	// latched item
	logic [1:0]        mode_q;
	logic [POS_W-1:0]  tp_q, mc_q, mh_q;
	logic              bounds_q;
	logic [TIME_W-1:0] time_q;

	// tracking state
	logic [POS_W-1:0]        prev_marker_q, prev_target_q, good_height_q, good_center_q;
	logic                    prev_marker_valid_q, prev_target_valid_q, good_center_valid_q;
	logic                    prev_time_valid_q;
	logic [TIME_W-1:0]       prev_time_q;
	logic signed [VEL_W-1:0] mvel_q, tvel_q, ptvel_q, accel_q;
	logic [CNT_W-1:0]        run_misses_q, total_misses_q;

	// work registers
	state_t                     state_q;
	logic [DT_W-1:0]            dt_q;
	logic                       decay_q, mvalid_q, tvalid_q;
	logic [6:0]                 factor_q;
	logic signed [POS_W:0]      mdiff_q, tdiff_q;
	logic [1:0]                 chan_q;
	logic signed [MUL_B_W-1:0]  raw_q;
	logic signed [PROD_W-1:0]   prod_q, sum_q;
	logic                       div_run_q;
	logic [RATIO_W-1:0]         ratio_q;
	logic [POS_W-1:0]           res_tp_q, res_mc_q, res_mh_q;
	logic                       rel_q, end_q;
	logic                       out_valid_q;

	// prep logic
	logic [POS_W-1:0]  mc_g, mh_g, tp_g, mh_o;
	logic [TIME_W-1:0] tdelta;
	logic [DT_W-1:0]   dt_n;
	logic [POS_W-1:0]  reset_jump;
	logic              long_miss, decay_n, mvalid_n;
	logic [6:0]        factor_n;
	logic [CNT_W-1:0]  run_inc, total_inc;

	// shared units
	logic [MUL_A_W-1:0]         mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic [ALPHA_W-1:0]         alpha;
	logic [CAP_W-1:0]           cap;
	logic signed [VEL_W-1:0]    old_v;
	logic signed [VEL_W-1:0]    ema_v;
	logic signed [PROD_W-1:0]   prod_mag;
	div_req_t                   div_req;
	logic                       div_done;
	logic [DIV_NUM_W-1:0]       div_quot;
	logic                       out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		long_miss = run_misses_q >= CNT_W'(2);
		mc_g = mc_q;
		mh_g = mh_q;
		if (!bounds_q && good_center_valid_q &&
				abs_diff(mc_q, good_center_q) > {1'b0, mjump_q}) begin
			mc_g = good_center_q;
			mh_g = good_height_q;
		end
		tp_g = tp_q;
		if (prev_target_valid_q && abs_diff(tp_q, prev_target_q) > {1'b0, tjump_q})
			tp_g = prev_target_q;
		mh_o = mh_g;
		if (mh_g < minh_q && good_height_q != '0)
			mh_o = good_height_q;
		tdelta = time_q - prev_time_q;
		dt_n = DT_W'(BASE_STEP_MS);
		if (prev_time_valid_q && time_q > prev_time_q)
			dt_n = (tdelta > TIME_W'(1000)) ? DT_W'(1000) : tdelta[DT_W-1:0];
		reset_jump = (mjump_q < POS_W'(50)) ? POS_W'(50) : mjump_q;
		decay_n = long_miss || dt_n > DT_W'(300);
		factor_n = 7'd77;
		if (dt_n > DT_W'(800))
			factor_n = 7'd0;
		else if (dt_n > DT_W'(500))
			factor_n = 7'd26;
		mvalid_n = prev_marker_valid_q && !decay_n &&
			!(abs_diff(mc_g, prev_marker_q) > {1'b0, reset_jump});
		run_inc   = (run_misses_q == CNT_MAX) ? CNT_MAX : run_misses_q + 1'b1;
		total_inc = (total_misses_q == CNT_MAX) ? CNT_MAX : total_misses_q + 1'b1;
	end

	always_comb begin
		case (chan_q)
			CH_MARKER: begin
				alpha = va_q;
				cap   = (mcap_q < CAP_W'(256)) ? CAP_W'(256) : mcap_q;
				old_v = mvel_q;
			end
			CH_TARGET: begin
				alpha = va_q;
				cap   = (tcap_q < CAP_W'(256)) ? CAP_W'(256) : tcap_q;
				old_v = tvel_q;
			end
			default: begin
				alpha = aa_q;
				cap   = (acap_q < CAP_W'(128)) ? CAP_W'(128) : acap_q;
				old_v = accel_q;
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			// step ratio by reciprocal multiply, taken in S_RATIO
			S_PREP: begin
				mul_a = dt_n;
				mul_b = RATIO_MUL;
			end
			S_DEC1: begin
				mul_a = MUL_A_W'(factor_q);
				mul_b = MUL_B_W'(tvel_q);
			end
			S_DEC2: begin
				mul_a = MUL_A_W'(factor_q);
				mul_b = MUL_B_W'(accel_q);
			end
			S_DIFF: begin
				mul_a = MUL_A_W'(BASE_STEP_MS);
				mul_b = (chan_q == CH_MARKER) ? MUL_B_W'(mdiff_q) : MUL_B_W'(tdiff_q);
			end
			S_EMA1: begin
				mul_a = MUL_A_W'(alpha);
				mul_b = raw_q;
			end
			S_EMA2: begin
				mul_a = MUL_A_W'(10'd256 - MUL_A_W'(alpha));
				mul_b = MUL_B_W'(old_v);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_mag = (prod_q < 0) ? -prod_q : prod_q;
	assign ema_v = clamp_mag(rnd8(sum_q + prod_q), cap);

	always_comb begin
		div_req.start = (state_q == S_VDIV) && !div_run_q;
		div_req.num   = {prod_mag[23:0], 8'd0} + DIV_NUM_W'(dt_q[DT_W-1:1]);
		div_req.den   = dt_q;
	end

	pvt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		prod_q <= $signed({1'b0, mul_a}) * mul_b;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q    <= ALPHA_W'(77);
			aa_q    <= ALPHA_W'(77);
			mcap_q  <= CAP_W'(25600);
			tcap_q  <= CAP_W'(25600);
			acap_q  <= CAP_W'(12800);
			mjump_q <= POS_W'(80);
			tjump_q <= POS_W'(80);
			minh_q  <= POS_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VEL_ALPHA:   va_q    <= alpha_clamp(cfg_data[ALPHA_W-1:0]);
				REG_ACCEL_ALPHA: aa_q    <= alpha_clamp(cfg_data[ALPHA_W-1:0]);
				REG_MARKER_CAP:  mcap_q  <= cfg_data;
				REG_TARGET_CAP:  tcap_q  <= cfg_data;
				REG_ACCEL_CAP:   acap_q  <= cfg_data;
				REG_MARKER_JUMP: mjump_q <= cfg_data[POS_W-1:0];
				REG_TARGET_JUMP: tjump_q <= cfg_data[POS_W-1:0];
				REG_MIN_HEIGHT:  minh_q  <= cfg_data[POS_W-1:0];
				default:         minh_q  <= minh_q;
			endcase
		end
	end

	// payload latched on accept
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_q   <= mode;
			tp_q     <= target_pos;
			mc_q     <= marker_center;
			mh_q     <= marker_height;
			bounds_q <= has_bounds;
			time_q   <= time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= S_IDLE;
			prev_marker_q       <= '0;
			prev_target_q       <= '0;
			good_height_q       <= '0;
			good_center_q       <= '0;
			prev_marker_valid_q <= 1'b0;
			prev_target_valid_q <= 1'b0;
			good_center_valid_q <= 1'b0;
			prev_time_valid_q   <= 1'b0;
			prev_time_q         <= '0;
			mvel_q              <= '0;
			tvel_q              <= '0;
			ptvel_q             <= '0;
			accel_q             <= '0;
			run_misses_q        <= '0;
			total_misses_q      <= '0;
			div_run_q           <= 1'b0;
			out_valid_q         <= 1'b0;
		end else begin
			if (state_q != S_OUT && out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					if (mode_q != MODE_DETECT) begin
						res_tp_q <= '0;
						res_mc_q <= '0;
						res_mh_q <= '0;
						ratio_q  <= '0;
					end
					rel_q <= (mode_q == MODE_MISS) && (run_inc >= REL_CNT);
					end_q <= (mode_q == MODE_MISS) && (total_inc >= END_CNT);
					case (mode_q)
						MODE_RESTART: begin
							run_misses_q        <= '0;
							total_misses_q      <= '0;
							prev_marker_valid_q <= 1'b0;
							prev_target_valid_q <= 1'b0;
							mvel_q              <= '0;
							tvel_q              <= '0;
							prev_time_valid_q   <= 1'b0;
							good_height_q       <= '0;
							good_center_q       <= '0;
							good_center_valid_q <= 1'b0;
							state_q             <= S_OUT;
						end
						MODE_MISS: begin
							run_misses_q   <= run_inc;
							total_misses_q <= total_inc;
							state_q        <= S_OUT;
						end
						MODE_DETECT: begin
							run_misses_q   <= '0;
							total_misses_q <= '0;
							if (mh_g >= minh_q)
								good_height_q <= mh_g;
							if (bounds_q) begin
								good_center_q       <= mc_g;
								good_center_valid_q <= 1'b1;
							end
							prev_time_q         <= time_q;
							prev_time_valid_q   <= 1'b1;
							dt_q                <= dt_n;
							decay_q             <= decay_n;
							factor_q            <= factor_n;
							mvalid_q            <= mvalid_n;
							tvalid_q            <= prev_target_valid_q && !decay_n;
							mdiff_q             <= $signed({1'b0, mc_g}) - $signed({1'b0, prev_marker_q});
							tdiff_q             <= $signed({1'b0, tp_g}) - $signed({1'b0, prev_target_q});
							prev_marker_q       <= mc_g;
							prev_marker_valid_q <= 1'b1;
							prev_target_q       <= tp_g;
							prev_target_valid_q <= 1'b1;
							res_tp_q            <= tp_g;
							res_mc_q            <= mc_g;
							res_mh_q            <= mh_o;
							chan_q              <= CH_MARKER;
							state_q             <= S_RATIO;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_RATIO: begin
					ratio_q <= RATIO_W'((prod_q + RATIO_ADD) >>> RATIO_SH);
					state_q <= decay_q ? S_DEC1 : S_CHAN;
				end
				S_DEC1: state_q <= S_DEC2;
				S_DEC2: begin
					ptvel_q <= VEL_W'(rnd8(prod_q));
					state_q <= S_DEC3;
				end
				S_DEC3: begin
					accel_q <= VEL_W'(rnd8(prod_q));
					state_q <= S_CHAN;
				end
				S_CHAN: begin
					case (chan_q)
						CH_MARKER: begin
							if (mvalid_q) begin
								state_q <= S_DIFF;
							end else begin
								mvel_q <= '0;
								chan_q <= CH_TARGET;
							end
						end
						CH_TARGET: begin
							if (tvalid_q) begin
								state_q <= S_DIFF;
							end else begin
								tvel_q <= '0;
								chan_q <= CH_ACCEL;
							end
						end
						default: begin
							raw_q   <= MUL_B_W'(tvel_q) - MUL_B_W'(ptvel_q);
							state_q <= S_EMA1;
						end
					endcase
				end
				S_DIFF: state_q <= S_VDIV;
				S_VDIV: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
						sum_q     <= prod_q;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						raw_q     <= (sum_q < 0) ? -$signed(div_quot) : $signed(div_quot);
						state_q   <= S_EMA1;
					end
				end
				S_EMA1: state_q <= S_EMA2;
				S_EMA2: begin
					sum_q   <= prod_q;
					state_q <= S_EMA3;
				end
				S_EMA3: begin
					case (chan_q)
						CH_MARKER: begin
							mvel_q  <= ema_v;
							chan_q  <= CH_TARGET;
							state_q <= S_CHAN;
						end
						CH_TARGET: begin
							tvel_q  <= ema_v;
							chan_q  <= CH_ACCEL;
							state_q <= S_CHAN;
						end
						default: begin
							accel_q <= ema_v;
							ptvel_q <= tvel_q;
							state_q <= S_OUT;
						end
					endcase
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register, loaded as the sequencer leaves S_OUT
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			target_out      <= res_tp_q;
			marker_out      <= res_mc_q;
			height_out      <= res_mh_q;
			marker_velocity <= mvel_q;
			target_velocity <= tvel_q;
			target_accel    <= accel_q;
			step_ratio      <= ratio_q;
			release_request <= rel_q;
			round_end       <= end_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/pvt_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on pvt_pkg for widths and the request struct.
`timescale 1ns / 1ps

module pvt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pvt_pkg::div_req_t             req,
	output logic                          done,
	output logic [pvt_pkg::DIV_NUM_W-1:0] quot
);
	import pvt_pkg::*;

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   sub;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign sub   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ----- rtl/pvt_check.sv -----
// Port-level checker for position_velocity_tracker, bound to the top level.
// Depends on assert_macros.svh and pvt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pvt_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [pvt_pkg::POS_W-1:0]          target_out,
	input logic [pvt_pkg::POS_W-1:0]          height_out,
	input logic signed [pvt_pkg::VEL_W-1:0]   marker_velocity,
	input logic [pvt_pkg::RATIO_W-1:0]        step_ratio,
	input logic                               release_request,
	input logic                               round_end
);
	import pvt_pkg::*;

	// one item at a time: an accepted item closes the input
	`CHK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open while busy")
	// miss flags come only from missed frames, which carry no ratio or position
	`CHK_IMPL(a_release_no_ratio, out_valid && release_request, step_ratio == '0 && target_out == '0, "release with detection data")
	`CHK_IMPL(a_end_no_height, out_valid && round_end, height_out == '0 && step_ratio == '0, "round end with detection data")
	// a waiting result holds
	`CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(marker_velocity) && $stable(step_ratio), "stalled result changed")

endmodule

bind position_velocity_tracker pvt_check u_pvt_check (.*);

// ----- dv/pvt_checker.sv -----
// Checker for the position and velocity tracker: watches config writes and both channels.
// Predicts each frame's result item and compares it field by field. Depends on pvt_pkg.
`timescale 1ns / 1ps

module pvt_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic [pvt_pkg::POS_W-1:0]        target_pos,
	input  logic [pvt_pkg::POS_W-1:0]        marker_center,
	input  logic [pvt_pkg::POS_W-1:0]        marker_height,
	input  logic                             has_bounds,
	input  logic [pvt_pkg::TIME_W-1:0]       time_ms,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [pvt_pkg::POS_W-1:0]        target_out,
	input  logic [pvt_pkg::POS_W-1:0]        marker_out,
	input  logic [pvt_pkg::POS_W-1:0]        height_out,
	input  logic [pvt_pkg::VEL_W-1:0]        marker_velocity,
	input  logic [pvt_pkg::VEL_W-1:0]        target_velocity,
	input  logic [pvt_pkg::VEL_W-1:0]        target_accel,
	input  logic [pvt_pkg::RATIO_W-1:0]      step_ratio,
	input  logic                             release_request,
	input  logic                             round_end,
	input  logic                             cfg_we,
	input  logic [pvt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pvt_pkg::CFG_W-1:0]        cfg_data,
	output int                               pending,
	output int                               fail_count
);
	import pvt_pkg::*;

	localparam longint BASE_MS = 16;
	localparam longint RELEASE_FRAMES = 3;
	localparam longint ROUND_FRAMES = 30;

	typedef struct packed {
		logic [POS_W-1:0]   tgt;
		logic [POS_W-1:0]   mrk;
		logic [POS_W-1:0]   hgt;
		logic [VEL_W-1:0]   mvel;
		logic [VEL_W-1:0]   tvel;
		logic [VEL_W-1:0]   tacc;
		logic [RATIO_W-1:0] ratio;
		logic               rel;
		logic               rnd_end;
	} frame_result_t;

	frame_result_t expected_frames[$];

	logic [CFG_W-1:0] regs[8];
	longint last_marker, last_target, kept_height, kept_center;
	bit last_marker_ok, last_target_ok, kept_center_ok, last_time_ok;
	longint mvel_s, tvel_s, last_tvel, accel_s;
	logic [TIME_W-1:0] last_time;
	longint run_miss, total_miss;

	function automatic longint rdiv(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint clampm(longint v, longint cap);
		if (v > cap)
			return cap;
		if (v < -cap)
			return -cap;
		return v;
	endfunction

	function automatic longint lim_alpha(longint r);
		if (r < 13)
			return 13;
		if (r > 256)
			return 256;
		return r;
	endfunction

	function automatic longint smooth(longint a, longint raw, longint old);
		return rdiv(a * raw + (256 - a) * old, 256);
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	task automatic clear_tracking();
		foreach (regs[i])
			regs[i] = '0;
		regs[REG_VEL_ALPHA] = 77;
		regs[REG_ACCEL_ALPHA] = 77;
		regs[REG_MARKER_CAP] = 25600;
		regs[REG_TARGET_CAP] = 25600;
		regs[REG_ACCEL_CAP] = 12800;
		regs[REG_MARKER_JUMP] = 80;
		regs[REG_TARGET_JUMP] = 80;
		regs[REG_MIN_HEIGHT] = 10;
		last_marker = 0; last_target = 0; kept_height = 0; kept_center = 0;
		last_marker_ok = 0; last_target_ok = 0; kept_center_ok = 0; last_time_ok = 0;
		mvel_s = 0; tvel_s = 0; last_tvel = 0; accel_s = 0;
		last_time = '0;
		run_miss = 0; total_miss = 0;
	endtask

	task automatic track_frame(output frame_result_t r);
		longint tp, mc, mh, dt, va, aa, mcap, tcap, acap, mjump, tjump, minh, rjump, f, raw;
		bit long_miss;
		tp = target_pos; mc = marker_center; mh = marker_height;
		r = '0;
		if (mode == MODE_RESTART) begin
			total_miss = 0; run_miss = 0;
			last_marker_ok = 0; last_target_ok = 0;
			mvel_s = 0; tvel_s = 0;
			last_time_ok = 0;
			kept_height = 0; kept_center = 0; kept_center_ok = 0;
		end else if (mode == MODE_MISS) begin
			if (total_miss < 255)
				total_miss++;
			if (run_miss < 255)
				run_miss++;
			r.rel = run_miss >= RELEASE_FRAMES;
			r.rnd_end = total_miss >= ROUND_FRAMES;
		end else if (mode == MODE_DETECT) begin
			long_miss = run_miss >= 2;
			dt = BASE_MS;
			va = lim_alpha(regs[REG_VEL_ALPHA][8:0]);
			aa = lim_alpha(regs[REG_ACCEL_ALPHA][8:0]);
			mcap = regs[REG_MARKER_CAP] < 256 ? 256 : regs[REG_MARKER_CAP];
			tcap = regs[REG_TARGET_CAP] < 256 ? 256 : regs[REG_TARGET_CAP];
			acap = regs[REG_ACCEL_CAP] < 128 ? 128 : regs[REG_ACCEL_CAP];
			mjump = regs[REG_MARKER_JUMP][11:0];
			tjump = regs[REG_TARGET_JUMP][11:0];
			minh = regs[REG_MIN_HEIGHT][11:0];
			rjump = mjump < 50 ? 50 : mjump;
			total_miss = 0; run_miss = 0;
			if (!has_bounds && kept_center_ok && absl(mc - kept_center) > mjump) begin
				mc = kept_center;
				mh = kept_height;
			end
			if (last_target_ok && absl(tp - last_target) > tjump)
				tp = last_target;
			if (mh >= minh)
				kept_height = mh;
			else if (kept_height > 0)
				mh = kept_height;
			if (has_bounds) begin
				kept_center = mc;
				kept_center_ok = 1;
			end
			if (last_time_ok && time_ms > last_time) begin
				dt = longint'(time_ms - last_time);
				if (dt > 1000)
					dt = 1000;
			end
			last_time = time_ms;
			last_time_ok = 1;
			r.ratio = RATIO_W'((dt * 256 + BASE_MS / 2) / BASE_MS);
			if (last_marker_ok && absl(mc - last_marker) > rjump) begin
				last_marker_ok = 0;
				mvel_s = 0;
			end
			// decay the estimates after a long gap or several misses
			if (long_miss || dt > 300) begin
				f = 77;
				if (dt > 500)
					f = 26;
				if (dt > 800)
					f = 0;
				mvel_s = rdiv(mvel_s * f, 256);
				tvel_s = rdiv(tvel_s * f, 256);
				accel_s = rdiv(accel_s * f, 256);
				last_tvel = tvel_s;
				last_marker_ok = 0;
				last_target_ok = 0;
			end
			if (!last_marker_ok) begin
				mvel_s = 0;
			end else begin
				raw = rdiv((mc - last_marker) * BASE_MS * 256, dt);
				mvel_s = clampm(smooth(va, raw, mvel_s), mcap);
			end
			if (!last_target_ok) begin
				tvel_s = 0;
			end else begin
				raw = rdiv((tp - last_target) * BASE_MS * 256, dt);
				tvel_s = clampm(smooth(va, raw, tvel_s), tcap);
			end
			accel_s = clampm(smooth(aa, tvel_s - last_tvel, accel_s), acap);
			last_tvel = tvel_s;
			last_marker = mc; last_marker_ok = 1;
			last_target = tp; last_target_ok = 1;
			r.tgt = POS_W'(tp); r.mrk = POS_W'(mc); r.hgt = POS_W'(mh);
		end
		r.mvel = mvel_s[VEL_W-1:0];
		r.tvel = tvel_s[VEL_W-1:0];
		r.tacc = accel_s[VEL_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t e, a;
		if (!arst_n) begin
			clear_tracking();
			expected_frames.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VEL_ALPHA, REG_ACCEL_ALPHA: regs[cfg_index] = cfg_data & 20'h1FF;
					REG_MARKER_CAP, REG_TARGET_CAP, REG_ACCEL_CAP: regs[cfg_index] = cfg_data;
					default: regs[cfg_index] = cfg_data & 20'hFFF;
				endcase
			end
			if (in_valid && !in_stall) begin
				track_frame(e);
				expected_frames.insert(expected_frames.size(), e);
			end
			if (out_valid && !out_stall) begin
				a = '{target_out, marker_out, height_out, marker_velocity, target_velocity,
					target_accel, step_ratio, release_request, round_end};
				if (expected_frames.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result item: %p", a);
				end else begin
					e = expected_frames[0];
					expected_frames.delete(0);
					if (a !== e) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch at %0t\n  expected %p\n  actual   %p", $realtime, e, a);
					end
				end
			end
		end
		pending = expected_frames.size();
	end

endmodule

// ----- dv/tb_top.sv -----
// Top of the tracker testbench: clock, reset, frame stimulus, receiver stalls, verdict.
// Depends on pvt_pkg, position_velocity_tracker and pvt_checker.
`timescale 1ns / 1ps

module tb_top;
	import pvt_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [1:0] mode = MODE_RESTART;
	logic [POS_W-1:0] target_pos = 0, marker_center = 0, marker_height = 0;
	logic has_bounds = 0;
	logic [TIME_W-1:0] time_ms = 0;
	logic out_valid, out_stall = 0;
	logic [POS_W-1:0] target_out, marker_out, height_out;
	logic signed [VEL_W-1:0] marker_velocity, target_velocity, target_accel;
	logic [RATIO_W-1:0] step_ratio;
	logic release_request, round_end;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_VEL_ALPHA;
	logic [CFG_W-1:0] cfg_data = 0;
	int pending, fail_count;
	bit quiet = 0, hold_req = 0;
	int idle_cycles = 0;

	logic [TIME_W-1:0] now_ms;
	logic [POS_W-1:0] walk_tp, walk_mc;

	always #5 clk = ~clk;

	position_velocity_tracker dut (.*);
	pvt_checker chk (.*);

	// receiver: random stalls, one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1;
				out_stall = 1;
				repeat (400) @(negedge clk);
			end
			out_stall = !quiet && ($urandom_range(99) < 16);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(logic [1:0] m, logic [11:0] tp, logic [11:0] mc, logic [11:0] mh,
			logic hb, logic [31:0] t);
		if (!quiet && $urandom_range(99) < 16) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		mode = m; target_pos = tp; marker_center = mc; marker_height = mh;
		has_bounds = hb; time_ms = t;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_noise(logic [1:0] m);
		send(m, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), 1'($urandom),
			$urandom);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic set_all(logic [8:0] va, logic [8:0] aa, logic [19:0] mcap,
			logic [19:0] tcap, logic [19:0] acap, logic [11:0] mj, logic [11:0] tj,
			logic [11:0] mh);
		set_reg(REG_VEL_ALPHA, CFG_W'(va));
		set_reg(REG_ACCEL_ALPHA, CFG_W'(aa));
		set_reg(REG_MARKER_CAP, mcap);
		set_reg(REG_TARGET_CAP, tcap);
		set_reg(REG_ACCEL_CAP, acap);
		set_reg(REG_MARKER_JUMP, CFG_W'(mj));
		set_reg(REG_TARGET_JUMP, CFG_W'(tj));
		set_reg(REG_MIN_HEIGHT, CFG_W'(mh));
	endtask

	function automatic logic [11:0] step_pos(logic [11:0] p, int span);
		return p + 12'($urandom_range(0, 2 * span)) - 12'(span);
	endfunction

	task automatic random_frames(int count);
		int n, r, len;
		n = 0;
		while (n < count) begin
			r = $urandom_range(99);
			if (r < 3) begin
				send_noise(MODE_RESTART);
				n++;
			end else if (r < 12) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(28, 35) : $urandom_range(1, 5);
				repeat (len) send_noise(MODE_MISS);
				n += len;
			end else if (r < 14) begin
				send_noise(MODE_SPARE);
				n++;
			end else if (r < 20) begin
				send_noise(MODE_DETECT);
				n++;
			end else begin
				r = $urandom_range(99);
				if (r < 5)
					now_ms += $urandom_range(250, 1200);
				else if (r < 8)
					now_ms -= $urandom_range(0, 5);
				else
					now_ms += $urandom_range(1, 40);
				walk_tp = step_pos(walk_tp, ($urandom_range(9) == 0) ? 300 : 20);
				walk_mc = step_pos(walk_mc, ($urandom_range(9) == 0) ? 300 : 20);
				send(MODE_DETECT, walk_tp, walk_mc,
					($urandom_range(4) == 0) ? POS_W'($urandom_range(0, 12)) :
						POS_W'($urandom_range(5, 100)),
					1'($urandom_range(1)), now_ms);
				n++;
			end
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed frames with default settings
		send(MODE_RESTART, 0, 0, 0, 0, 0);
		send(MODE_DETECT, 100, 200, 30, 1, 1000);
		send(MODE_DETECT, 110, 205, 30, 1, 1016);
		send(MODE_DETECT, 4095, 4095, 4095, 1, 32'hFFFF_FFF0);
		send(MODE_DETECT, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send(MODE_DETECT, 5, 3000, 2, 0, 32'hFFFF_FFFF);
		send(MODE_DETECT, 8, 10, 4, 1, 5);
		send(MODE_DETECT, 12, 14, 40, 1, 20);
		send(MODE_DETECT, 20, 22, 40, 1, 420);
		send(MODE_DETECT, 25, 30, 40, 1, 1020);
		send(MODE_DETECT, 30, 35, 40, 1, 1920);
		send(MODE_DETECT, 40, 45, 40, 1, 5000);
		send(MODE_MISS, 0, 0, 0, 0, 0);
		send(MODE_MISS, 0, 0, 0, 0, 0);
		send(MODE_MISS, 0, 0, 0, 0, 0);
		send(MODE_DETECT, 44, 50, 40, 0, 5016);
		send(MODE_SPARE, 4095, 4095, 4095, 1, 32'hFFFF_FFFF);
		send(MODE_DETECT, 50, 56, 40, 1, 5032);
		send(MODE_RESTART, 4095, 4095, 4095, 1, 32'hFFFF_FFFF);
		send(MODE_DETECT, 60, 70, 40, 0, 5048);

		now_ms = $urandom;
		walk_tp = POS_W'($urandom);
		walk_mc = POS_W'($urandom);
		random_frames(400);

		set_all(0, 0, 0, 0, 0, 0, 0, 0);
		quiet = 1;
		random_frames(400);
		quiet = 0;

		set_all(9'h1FF, 9'h1FF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		hold_req = 1;
		random_frames(400);

		set_all(9'($urandom_range(13, 256)), 9'($urandom_range(13, 256)),
			20'($urandom_range(256, 40000)), 20'($urandom_range(256, 40000)),
			20'($urandom_range(128, 20000)), 12'($urandom_range(20, 200)),
			12'($urandom_range(20, 200)), 12'($urandom_range(0, 30)));
		random_frames(500);
		in_valid = 0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pvt_pkg.sv
rtl/pvt_div.sv
rtl/position_velocity_tracker.sv
rtl/pvt_check.sv
dv/pvt_checker.sv
dv/tb_top.sv
